// File: rtl/core/qslerp_pkg.sv
package qslerp_pkg;

    localparam int COMP_LIMIT   = 16384;
    localparam int PROG_ONE     = 32768;
    localparam int SCALE_LOG2   = 40;
    localparam int DOT_ONE_LOG2 = 28;
    localparam int TINY_RECIP   = 100000;
    localparam int ATAN_STAGES  = 32;

    // atan(2^-i) in Q30, rounded to nearest
    localparam longint ATAN_Q30 [ATAN_STAGES] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2, 1, 0
    };

    // quaternion components, progress and the bypass flag that travel along the chain up to the output cell
    typedef struct packed {
        logic [3:0][16:0] f;
        logic [3:0][15:0] t;
        logic [15:0]      prog;
        logic             byp;
    } side_t;

    function automatic longint q30_to_w(longint v, int w);
        int sh;
        sh = 30 - w;
        if (sh == 0) begin
            return v;
        end
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint atan_w(int i, int w);
        return q30_to_w(ATAN_Q30[i], w);
    endfunction

    function automatic logic [63:0] isqrt64(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] x;
        r = '0;
        b = 64'd1 << 62;
        x = v;
        while (b > x) begin
            b = b >> 2;
        end
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // shift-subtract quotient, elaboration use only
    function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], n[i]};
            if (r >= d) begin
                r = r - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic longint inv_gain_w(int n, int w);
        logic [63:0] g;
        logic [63:0] f;
        logic [63:0] d;
        g = 64'd1 << 30;
        for (int i = 0; i < n; i++) begin
            f = 64'd1 << 30;
            if (2 * i <= 60) begin
                d = isqrt64((64'd1 << 60) + (64'd1 << (60 - 2 * i)));
                f = udiv64(64'd1 << 60, d);
            end
            g = (g * f) >> 30;
        end
        return q30_to_w(longint'(g), w);
    endfunction

endpackage

// File: rtl/core/qslerp_sqrt_cell.sv
module qslerp_sqrt_cell #(
    parameter int RB = 15,
    parameter int B  = 0
) (
    input  logic            aclk,
    input  logic            en,
    input  logic [2*RB-1:0] rem_in,
    input  logic [RB-1:0]   root_in,
    input  logic [RB-1:0]   c_in,
    output logic [2*RB-1:0] rem_out,
    output logic [RB-1:0]   root_out,
    output logic [RB-1:0]   c_out
);
    localparam int QW = 2 * RB;
    localparam int TW = QW + 1;

    logic [TW-1:0] trial;
    logic          fits;
    logic [QW-1:0] rem_next;
    logic [RB-1:0] root_next;
    logic [QW-1:0] rem_reg;
    logic [RB-1:0] root_reg;
    logic [RB-1:0] c_reg;

    // try root bit B: (P + 2^B)^2 <= v  <=>  rem >= 2P*2^B + 2^2B
    always_comb begin
        trial     = (TW'(root_in) << (B + 1)) + (TW'(1) << (2 * B));
        fits      = {1'b0, rem_in} >= trial;
        rem_next  = fits ? QW'({1'b0, rem_in} - trial) : rem_in;
        root_next = fits ? (root_in | (RB'(1) << B)) : root_in;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            c_reg    <= c_in;
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign c_out    = c_reg;
endmodule

// File: rtl/core/qslerp_cordic_cell.sv
module qslerp_cordic_cell
    import qslerp_pkg::*;
#(
    parameter int W    = 14,
    parameter int I    = 0,
    parameter bit VECT = 1'b1
) (
    input  logic              aclk,
    input  logic              en,
    input  logic signed [W+2:0] x_in,
    input  logic signed [W+2:0] y_in,
    input  logic signed [W+2:0] z_in,
    output logic signed [W+2:0] x_out,
    output logic signed [W+2:0] y_out,
    output logic signed [W+2:0] z_out
);
    localparam int XW = W + 3;
    localparam logic signed [XW-1:0] DA = XW'(atan_w(I, W));

    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic                 up;
    logic signed [XW-1:0] x_next;
    logic signed [XW-1:0] y_next;
    logic signed [XW-1:0] z_next;
    logic signed [XW-1:0] x_reg;
    logic signed [XW-1:0] y_reg;
    logic signed [XW-1:0] z_reg;

    always_comb begin
        dx = y_in >>> I;
        dy = x_in >>> I;
        // vectoring drives y to zero, rotation drives z to zero
        up = VECT ? !(y_in > 0) : (z_in >= 0);
        if (up) begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - DA;
        end else begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + DA;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
endmodule

// File: rtl/core/qslerp_div_cell.sv
module qslerp_div_cell #(
    parameter int NW = 30,
    parameter int DW = 16,
    parameter int RB = 15,
    parameter int B  = 0
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [NW-1:0] num_in,
    input  logic [DW-1:0] rem_in,
    input  logic [NW-1:0] quo_in,
    input  logic [RB-1:0] s_in,
    input  logic          neg_in,
    output logic [NW-1:0] num_out,
    output logic [DW-1:0] rem_out,
    output logic [NW-1:0] quo_out,
    output logic [RB-1:0] s_out,
    output logic          neg_out
);
    logic [DW-1:0] rem_sh;
    logic          fits;
    logic [DW-1:0] rem_next;
    logic [NW-1:0] quo_next;
    logic [NW-1:0] num_reg;
    logic [DW-1:0] rem_reg;
    logic [NW-1:0] quo_reg;
    logic [RB-1:0] s_reg;
    logic          neg_reg;

    // one restoring step: bring down numerator bit B
    always_comb begin
        rem_sh   = {rem_in[DW-2:0], num_in[B]};
        fits     = rem_sh >= DW'(s_in);
        rem_next = fits ? (rem_sh - DW'(s_in)) : rem_sh;
        quo_next = {quo_in[NW-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg <= num_in;
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            s_reg   <= s_in;
            neg_reg <= neg_in;
        end
    end

    assign num_out = num_reg;
    assign rem_out = rem_reg;
    assign quo_out = quo_reg;
    assign s_out   = s_reg;
    assign neg_out = neg_reg;
endmodule

// File: rtl/core/quaternion_slerp.sv
// Structure: a chain of register cells; the square root and divider rows each resolve
//   one bit per cell.
// Throughput: one word per cycle while m_ready does not stall the chain; every stage is
//   a register cell that advances when it is empty or when the cell after it advances.
// Reset: aresetn low clears every stage valid bit; data registers are not reset.
module quaternion_slerp
    import qslerp_pkg::*;
#(
    parameter int FRACTION_BITS   = 14,
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_from_x,
    input  logic signed [15:0] s_from_y,
    input  logic signed [15:0] s_from_z,
    input  logic signed [15:0] s_from_w,
    input  logic signed [15:0] s_to_x,
    input  logic signed [15:0] s_to_y,
    input  logic signed [15:0] s_to_z,
    input  logic signed [15:0] s_to_w,
    input  logic [15:0]        s_progress,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_out_x,
    output logic signed [15:0] m_out_y,
    output logic signed [15:0] m_out_z,
    output logic signed [15:0] m_out_w
);
    localparam int W   = FRACTION_BITS;
    localparam int N   = TRIG_ITERATIONS;
    localparam int RB  = W + 1;          // root / cosine bits, values up to 1.0
    localparam int QW  = 2 * RB;         // radicand bits
    localparam int XW  = W + 3;          // CORDIC datapath, signed
    localparam int NW  = 2 * W + 2;      // dividend and quotient bits
    localparam int DW  = W + 2;          // divider remainder bits
    localparam int SW  = SCALE_LOG2 + 2; // clamped scale, signed
    localparam int QX  = (NW > SW) ? NW : SW;
    localparam int PW  = SW + 17;
    localparam int AW  = PW + 1;
    localparam int C_SHL = (W >= DOT_ONE_LOG2) ? W - DOT_ONE_LOG2 : 0;
    localparam int C_SHR = (W >= DOT_ONE_LOG2) ? 0 : DOT_ONE_LOG2 - W;

    // stage map along the chain
    localparam int S_IN  = 0;
    localparam int S_DOT = 1;
    localparam int S_RAD = 2;
    localparam int S_SQ0 = 3;
    localparam int S_VC0 = S_SQ0 + RB;
    localparam int S_TH  = S_VC0 + N;
    localparam int S_RT0 = S_TH + 1;
    localparam int S_DV0 = S_RT0 + N;
    localparam int S_SCL = S_DV0 + NW;
    localparam int S_MUL = S_SCL + 1;
    localparam int S_OUT = S_MUL + 1;
    localparam int L     = S_OUT + 1;
    localparam int SPN   = S_DV0 - S_VC0;

    localparam logic [RB-1:0] ONE = RB'(1) << W;
    localparam logic [RB-1:0] TINY_MIN =
        RB'(((longint'(1) << W) + TINY_RECIP - 1) / TINY_RECIP);
    localparam logic signed [XW-1:0] K_INIT = XW'(inv_gain_w(N, W));
    localparam logic [QX-1:0] SCL_LIM = QX'(1) << SCALE_LOG2;

    // ---------------------------------------------------------------------------------
    // Handshake: each cell takes new data when it is empty or its successor moves on.
    // ---------------------------------------------------------------------------------
    logic [L-1:0] vld_reg;
    logic [L-1:0] vld_next;
    logic [L:0]   en;

    assign en[L] = m_ready;
    for (genvar k = 0; k < L; k++) begin : g_en
        assign en[k] = ~vld_reg[k] | en[k+1];
    end

    assign vld_next = (en[L-1:0] & {vld_reg[L-2:0], s_valid}) | (~en[L-1:0] & vld_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_ready = en[S_IN];
    assign m_valid = vld_reg[L-1];

    // ---------------------------------------------------------------------------------
    // Side band: quaternions, progress and the bypass flag ride along every cell up to the multiply cell.
    // ---------------------------------------------------------------------------------
    side_t side_reg  [S_MUL+1];
    side_t side_next [S_MUL+1];

    logic signed [15:0] fin [4];
    logic signed [15:0] tin [4];
    logic signed [31:0] prod_reg [4];

    assign fin[0] = s_from_x;
    assign fin[1] = s_from_y;
    assign fin[2] = s_from_z;
    assign fin[3] = s_from_w;
    assign tin[0] = s_to_x;
    assign tin[1] = s_to_y;
    assign tin[2] = s_to_z;
    assign tin[3] = s_to_w;

    // input cell: saturate progress, flag equal quaternions, form the four products
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            side_next[S_IN].f[j] = {fin[j][15], fin[j]};
            side_next[S_IN].t[j] = tin[j];
        end
        side_next[S_IN].prog = (s_progress > PROG_ONE) ? 16'(PROG_ONE) : s_progress;
        side_next[S_IN].byp  = (fin[0] == tin[0]) && (fin[1] == tin[1]) &&
                               (fin[2] == tin[2]) && (fin[3] == tin[3]);
    end

    always_ff @(posedge aclk) begin
        if (en[S_IN]) begin
            side_reg[S_IN] <= side_next[S_IN];
            for (int j = 0; j < 4; j++) begin
                prod_reg[j] <= 32'(fin[j]) * 32'(tin[j]);
            end
        end
    end

    // dot cell: sum, take the short path, truncate to RB bits and clamp to one
    logic signed [33:0] dot;
    logic               dot_neg;
    logic [33:0]        dot_abs;
    logic [RB-1:0]      c_next;
    logic [RB-1:0]      c_reg;

    always_comb begin
        dot     = 34'(prod_reg[0]) + 34'(prod_reg[1]) + 34'(prod_reg[2]) + 34'(prod_reg[3]);
        dot_neg = dot[33];
        dot_abs = dot_neg ? 34'(-dot) : 34'(dot);
        if (dot_abs >= (34'(1) << DOT_ONE_LOG2)) begin
            c_next = ONE;
        end else if (W >= DOT_ONE_LOG2) begin
            c_next = RB'(dot_abs[DOT_ONE_LOG2-1:0]) << C_SHL;
        end else begin
            c_next = RB'(dot_abs[DOT_ONE_LOG2-1:0] >> C_SHR);
        end
        side_next[S_DOT] = side_reg[S_DOT-1];
        for (int j = 0; j < 4; j++) begin
            if (!side_reg[S_DOT-1].byp && dot_neg) begin
                side_next[S_DOT].f[j] = 17'(-$signed(side_reg[S_DOT-1].f[j]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[S_DOT]) begin
            c_reg <= c_next;
        end
    end

    // radicand cell: one - c^2
    logic [QW-1:0] rad_reg;
    logic [RB-1:0] c2_reg;

    always_ff @(posedge aclk) begin
        if (en[S_RAD]) begin
            rad_reg <= (QW'(1) << (2 * W)) - QW'(c_reg) * QW'(c_reg);
            c2_reg  <= c_reg;
        end
    end

    // square root row: one root bit per cell, most significant first
    logic [QW-1:0] sq_rem  [RB+1];
    logic [RB-1:0] sq_root [RB+1];
    logic [RB-1:0] sq_c    [RB+1];

    assign sq_rem[0]  = rad_reg;
    assign sq_root[0] = '0;
    assign sq_c[0]    = c2_reg;

    for (genvar i = 0; i < RB; i++) begin : g_sqrt
        qslerp_sqrt_cell #(
            .RB(RB),
            .B (RB - 1 - i)
        ) u_cell (
            .aclk    (aclk),
            .en      (en[S_SQ0+i]),
            .rem_in  (sq_rem[i]),
            .root_in (sq_root[i]),
            .c_in    (sq_c[i]),
            .rem_out (sq_rem[i+1]),
            .root_out(sq_root[i+1]),
            .c_out   (sq_c[i+1])
        );
    end

    // sine of the half angle: hold it until the divider row
    logic [RB-1:0] sp_reg [SPN];

    for (genvar i = 0; i < SPN; i++) begin : g_sp
        always_ff @(posedge aclk) begin
            if (en[S_VC0+i]) begin
                sp_reg[i] <= (i == 0) ? sq_root[RB] : sp_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    // vectoring row: half angle from (c, s)
    logic signed [XW-1:0] vx [N+1];
    logic signed [XW-1:0] vy [N+1];
    logic signed [XW-1:0] vz [N+1];

    assign vx[0] = XW'(sq_c[RB]);
    assign vy[0] = XW'(sq_root[RB]);
    assign vz[0] = '0;

    for (genvar i = 0; i < N; i++) begin : g_vect
        qslerp_cordic_cell #(
            .W   (W),
            .I   (i),
            .VECT(1'b1)
        ) u_cell (
            .aclk (aclk),
            .en   (en[S_VC0+i]),
            .x_in (vx[i]),
            .y_in (vy[i]),
            .z_in (vz[i]),
            .x_out(vx[i+1]),
            .y_out(vy[i+1]),
            .z_out(vz[i+1])
        );
    end

    // theta cell: split the angle by progress, floor the Q15 product
    logic signed [XW+16:0] th_pa;
    logic signed [XW+16:0] th_pb;
    logic [16:0]           prog_c;
    logic signed [XW-1:0]  tha_reg;
    logic signed [XW-1:0]  thb_reg;

    always_comb begin
        prog_c = 17'(PROG_ONE) - {1'b0, side_reg[S_TH-1].prog};
        th_pb  = (XW+17)'(vz[N]) * (XW+17)'($signed({1'b0, side_reg[S_TH-1].prog}));
        th_pa  = (XW+17)'(vz[N]) * (XW+17)'($signed(prog_c));
    end

    always_ff @(posedge aclk) begin
        if (en[S_TH]) begin
            tha_reg <= XW'(th_pa >>> 15);
            thb_reg <= XW'(th_pb >>> 15);
        end
    end

    // rotation rows: two lanes, sine of each angle from (1/K, 0)
    logic signed [XW-1:0] rx [2][N+1];
    logic signed [XW-1:0] ry [2][N+1];
    logic signed [XW-1:0] rz [2][N+1];

    assign rx[0][0] = K_INIT;
    assign ry[0][0] = '0;
    assign rz[0][0] = tha_reg;
    assign rx[1][0] = K_INIT;
    assign ry[1][0] = '0;
    assign rz[1][0] = thb_reg;

    for (genvar l = 0; l < 2; l++) begin : g_rot_lane
        for (genvar i = 0; i < N; i++) begin : g_rot
            qslerp_cordic_cell #(
                .W   (W),
                .I   (i),
                .VECT(1'b0)
            ) u_cell (
                .aclk (aclk),
                .en   (en[S_RT0+i]),
                .x_in (rx[l][i]),
                .y_in (ry[l][i]),
                .z_in (rz[l][i]),
                .x_out(rx[l][i+1]),
                .y_out(ry[l][i+1]),
                .z_out(rz[l][i+1])
            );
        end
    end

    // divider rows: |sine| * 2^W / s, one quotient bit per cell
    logic [NW-1:0] dnum [2][NW+1];
    logic [DW-1:0] drem [2][NW+1];
    logic [NW-1:0] dquo [2][NW+1];
    logic [RB-1:0] ds   [2][NW+1];
    logic          dneg [2][NW+1];

    for (genvar l = 0; l < 2; l++) begin : g_div_lane
        logic signed [XW-1:0] sine;
        logic [XW-1:0]        mag;

        assign sine       = ry[l][N];
        assign mag        = sine[XW-1] ? XW'(-sine) : XW'(sine);
        assign dnum[l][0] = {mag[XW-2:0], {W{1'b0}}};
        assign drem[l][0] = '0;
        assign dquo[l][0] = '0;
        assign ds[l][0]   = sp_reg[SPN-1];
        assign dneg[l][0] = sine[XW-1];

        for (genvar i = 0; i < NW; i++) begin : g_div
            qslerp_div_cell #(
                .NW(NW),
                .DW(DW),
                .RB(RB),
                .B (NW - 1 - i)
            ) u_cell (
                .aclk   (aclk),
                .en     (en[S_DV0+i]),
                .num_in (dnum[l][i]),
                .rem_in (drem[l][i]),
                .quo_in (dquo[l][i]),
                .s_in   (ds[l][i]),
                .neg_in (dneg[l][i]),
                .num_out(dnum[l][i+1]),
                .rem_out(drem[l][i+1]),
                .quo_out(dquo[l][i+1]),
                .s_out  (ds[l][i+1]),
                .neg_out(dneg[l][i+1])
            );
        end
    end

    // scale cell: clamp the quotient magnitude and restore its sign
    logic signed [SW-1:0] w_reg [2];

    for (genvar l = 0; l < 2; l++) begin : g_scale
        logic [QX-1:0] qe;
        logic [QX-1:0] qc;

        assign qe = QX'(dquo[l][NW]);
        assign qc = (qe > SCL_LIM) ? SCL_LIM : qe;

        always_ff @(posedge aclk) begin
            if (en[S_SCL]) begin
                w_reg[l] <= dneg[l][NW] ? -SW'(qc) : SW'(qc);
            end
        end
    end

    // multiply cell: scaleA*F and scaleB*T per component
    logic signed [PW-1:0] pa_reg [4];
    logic signed [PW-1:0] pb_reg [4];

    always_ff @(posedge aclk) begin
        if (en[S_MUL]) begin
            for (int j = 0; j < 4; j++) begin
                pa_reg[j] <= PW'(w_reg[0]) * PW'($signed(side_reg[S_MUL-1].f[j]));
                pb_reg[j] <= PW'(w_reg[1]) * PW'($signed(side_reg[S_MUL-1].t[j]));
            end
        end
    end

    // pass the side band, drop in the tiny-sine bypass where s first shows up
    for (genvar k = 1; k <= S_MUL; k++) begin : g_side
        if (k == S_VC0) begin : g_tiny
            always_comb begin
                side_next[k]     = side_reg[k-1];
                side_next[k].byp = side_reg[k-1].byp || (sq_root[RB] < TINY_MIN);
            end
        end else if (k != S_DOT) begin : g_pass
            assign side_next[k] = side_reg[k-1];
        end
        always_ff @(posedge aclk) begin
            if (en[k]) begin
                side_reg[k] <= side_next[k];
            end
        end
    end

    // output cell: round, pick the bypass value, saturate to the component range
    logic signed [AW-1:0] acc  [4];
    logic signed [AW-1:0] vsel [4];
    logic signed [15:0]   out_next [4];
    logic signed [15:0]   out_reg  [4];

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            acc[j]  = AW'(pa_reg[j]) + AW'(pb_reg[j]) + (AW'(1) <<< (W - 1));
            vsel[j] = side_reg[S_MUL].byp ? AW'($signed(side_reg[S_MUL].f[j]))
                                          : (acc[j] >>> W);
            if (vsel[j] > COMP_LIMIT) begin
                out_next[j] = 16'(COMP_LIMIT);
            end else if (vsel[j] < -COMP_LIMIT) begin
                out_next[j] = 16'(-COMP_LIMIT);
            end else begin
                out_next[j] = vsel[j][15:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[S_OUT]) begin
            for (int j = 0; j < 4; j++) begin
                out_reg[j] <= out_next[j];
            end
        end
    end

    assign m_out_x = out_reg[0];
    assign m_out_y = out_reg[1];
    assign m_out_z = out_reg[2];
    assign m_out_w = out_reg[3];
endmodule

// File: rtl/core/qslerp_checker.sv
module qslerp_checker
    import qslerp_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic signed [15:0] s_from_x,
    input logic signed [15:0] s_from_y,
    input logic signed [15:0] s_from_z,
    input logic signed [15:0] s_from_w,
    input logic signed [15:0] s_to_x,
    input logic signed [15:0] s_to_y,
    input logic signed [15:0] s_to_z,
    input logic signed [15:0] s_to_w,
    input logic [15:0]        s_progress,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [15:0] m_out_x,
    input logic signed [15:0] m_out_y,
    input logic signed [15:0] m_out_z,
    input logic signed [15:0] m_out_w
);
    // hold a stalled result word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_x) && $stable(m_out_y) &&
                                $stable(m_out_z) && $stable(m_out_w))
        else $error("stalled result word changed");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_out_x >= -COMP_LIMIT && m_out_x <= COMP_LIMIT &&
                    m_out_y >= -COMP_LIMIT && m_out_y <= COMP_LIMIT &&
                    m_out_z >= -COMP_LIMIT && m_out_z <= COMP_LIMIT &&
                    m_out_w >= -COMP_LIMIT && m_out_w <= COMP_LIMIT)
        else $error("result component outside saturation range");

    // an empty output cell lets the whole chain advance
    a_ready_when_empty: assert property (@(posedge aclk)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output cell");
endmodule

bind quaternion_slerp qslerp_checker u_qslerp_checker (.*);

// File: sim/quaternion_slerp_test.sv
module quaternion_slerp_test;
    import qslerp_pkg::*;

    localparam int FBITS  = 14;
    localparam int STAGES = 16;
    localparam int LATENCY = 3 * FBITS + 2 * STAGES + 10;
    localparam longint CYCLE_LIMIT = 400000;

    // one input word: start quaternion, end quaternion, progress
    typedef struct {
        logic signed [15:0] f [4];
        logic signed [15:0] t [4];
        logic [15:0]        prog;
    } slerp_word_t;

    typedef struct {
        logic signed [15:0] q [4];
    } quat_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_from_x = '0, s_from_y = '0, s_from_z = '0, s_from_w = '0;
    logic signed [15:0] s_to_x = '0, s_to_y = '0, s_to_z = '0, s_to_w = '0;
    logic [15:0] s_progress = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [15:0] m_out_x, m_out_y, m_out_z, m_out_w;

    slerp_word_t pending_words[$];
    quat_t       expected_quats[$];
    int          mismatches = 0;
    longint      cycle = 0;
    bit          stimulus_done = 1'b0;
    bit          calm = 1'b0;          // long stretch with no idling on either side

    quaternion_slerp #(.FRACTION_BITS(FBITS), .TRIG_ITERATIONS(STAGES)) dut (.*);

    always #5 aclk = ~aclk;

    // ---------------- predictor ----------------
    function automatic longint floor_shr(longint v, int sh);
        return v >>> sh;    // arithmetic shift floors toward minus infinity
    endfunction

    function automatic longint atan_step(int i);
        longint sh;
        sh = 30 - FBITS;
        return floor_shr(ATAN_Q30[i] + (longint'(1) << (sh - 1)), sh);
    endfunction

    function automatic longint vector_angle(longint x, longint y);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i < STAGES; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (y > 0) begin
                x += dx; y -= dy; z += atan_step(i);
            end else begin
                x -= dx; y += dy; z -= atan_step(i);
            end
        end
        return z;
    endfunction

    function automatic longint rotated_sine(longint theta, longint k);
        longint x, y, z, dx, dy;
        x = k; y = 0; z = theta;
        for (int i = 0; i < STAGES; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_step(i);
            end else begin
                x += dx; y -= dy; z += atan_step(i);
            end
        end
        return y;
    endfunction

    function automatic longint root_floor(longint v);
        longint r, b;
        r = 0;
        b = longint'(1) << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint cordic_gain_inverse();
        longint g, f;
        g = longint'(1) << 30;
        for (int i = 0; i < STAGES; i++) begin
            f = (longint'(1) << 60) / root_floor((longint'(1) << 60) + (longint'(1) << (60 - 2 * i)));
            g = (g * f) >>> 30;
        end
        return floor_shr(g + (longint'(1) << (29 - FBITS)), 30 - FBITS);
    endfunction

    function automatic longint weight(longint sine, longint s);
        longint q, lim;
        lim = longint'(1) << SCALE_LOG2;
        q = (sine * (longint'(1) << FBITS)) / s;   // truncating division
        if (q > lim) q = lim;
        if (q < -lim) q = -lim;
        return q;
    endfunction

    function automatic logic signed [15:0] clip(longint v);
        if (v > COMP_LIMIT) v = COMP_LIMIT;
        if (v < -COMP_LIMIT) v = -COMP_LIMIT;
        return v[15:0];
    endfunction

    function automatic quat_t slerp_predict(slerp_word_t w);
        quat_t r;
        longint f[4], t[4], dot, c, s, a, k, wa, wb, one, p, acc;
        bit same;
        one = longint'(1) << FBITS;
        same = 1'b1;
        dot = 0;
        p = w.prog > PROG_ONE ? PROG_ONE : w.prog;
        for (int j = 0; j < 4; j++) begin
            f[j] = w.f[j];
            t[j] = w.t[j];
            if (f[j] != t[j]) same = 1'b0;
        end
        if (!same) begin
            for (int j = 0; j < 4; j++) dot += f[j] * t[j];
            if (dot < 0) begin
                for (int j = 0; j < 4; j++) f[j] = -f[j];
                dot = -dot;
            end
            c = dot >>> (DOT_ONE_LOG2 - FBITS);
            if (c > one) c = one;
            s = root_floor(one * one - c * c);
            // tiny sine: keep the (possibly flipped) start
            if (s * TINY_RECIP >= one) begin
                a = vector_angle(c, s);
                k = cordic_gain_inverse();
                wb = weight(rotated_sine(floor_shr(a * p, 15), k), s);
                wa = weight(rotated_sine(floor_shr(a * (PROG_ONE - p), 15), k), s);
                for (int j = 0; j < 4; j++) begin
                    acc = wa * f[j] + wb * t[j] + (longint'(1) << (FBITS - 1));
                    f[j] = floor_shr(acc, FBITS);
                end
            end
        end
        for (int j = 0; j < 4; j++) r.q[j] = clip(f[j]);
        return r;
    endfunction

    // ---------------- stimulus ----------------
    function automatic logic signed [15:0] rand_comp();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0) return 16'($urandom());            // anything, out of range too
        if (sel == 1) return 16'sd16384;
        if (sel == 2) return -16'sd16384;
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    // random unit quaternion in Q1.14
    function automatic void rand_unit(output logic signed [15:0] q [4]);
        real v[4], n;
        n = 0.0;
        for (int j = 0; j < 4; j++) begin
            v[j] = real'($signed($urandom_range(0, 2000)) - 1000);
            n += v[j] * v[j];
        end
        if (n == 0.0) begin
            v[3] = 1.0; n = 1.0;
        end
        n = $sqrt(n);
        for (int j = 0; j < 4; j++) q[j] = 16'($rtoi(v[j] / n * 16384.0));
    endfunction

    function automatic logic [15:0] rand_prog();
        int sel;
        sel = $urandom_range(0, 15);
        if (sel == 0) return 16'($urandom());            // above one is saturated
        if (sel == 1) return 16'd0;
        if (sel == 2) return 16'd32768;
        return 16'($urandom_range(0, 32768));
    endfunction

    task automatic add_word(logic signed [15:0] f [4], logic signed [15:0] t [4],
                            logic [15:0] p);
        slerp_word_t w;
        w.f = f;
        w.t = t;
        w.prog = p;
        pending_words.push_back(w);
    endtask

    initial begin
        logic signed [15:0] a [4], b [4];
        // directed: identity, extremes, equal inputs, opposite, near-equal, big progress
        a = '{16'sd0, 16'sd0, 16'sd0, 16'sd16384};
        b = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
        add_word(a, b, 16'd0);
        add_word(a, b, 16'd32768);
        add_word(a, b, 16'd16384);
        add_word(a, b, 16'hFFFF);
        add_word(a, a, 16'd12345);                       // equal quaternions
        b = '{16'sd0, 16'sd0, 16'sd0, -16'sd16384};
        add_word(a, b, 16'd16384);                       // opposite: flip, tiny sine
        b = '{16'sd0, 16'sd16384, 16'sd0, 16'sd0};
        add_word(b, a, 16'd8000);
        b = '{-16'sd16384, 16'sd0, 16'sd0, 16'sd0};
        add_word(a, b, 16'd20000);
        b = '{16'sd1, 16'sd0, 16'sd0, 16'sd16384};
        add_word(a, b, 16'd16384);                       // nearly equal
        a = '{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384};
        b = '{-16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384};
        add_word(a, b, 16'd9000);                        // out of unit range
        a = '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};
        b = '{16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA};
        add_word(a, b, 16'd30000);                       // raw extremes
        add_word(b, a, 16'hFFFF);
        b = '{16'h8000, 16'h8000, 16'h8000, 16'h8000};
        add_word(b, b, 16'd0);
        a = '{16'sd11585, 16'sd0, 16'sd0, 16'sd11585};
        b = '{-16'sd11585, 16'sd0, 16'sd0, 16'sd11585};
        add_word(a, b, 16'd16384);
        add_word(b, a, 16'd1);
        // random part: mostly unit quaternions, some raw noise
        for (int n = 0; n < 1650; n++) begin
            int sel;
            sel = $urandom_range(0, 9);
            if (sel < 7) begin
                rand_unit(a);
                rand_unit(b);
            end else if (sel == 7) begin
                rand_unit(a);
                b = a;
                if ($urandom_range(0, 1)) b[$urandom_range(0, 3)] += 16'($urandom_range(1, 3));
            end else begin
                for (int j = 0; j < 4; j++) begin
                    a[j] = rand_comp();
                    b[j] = rand_comp();
                end
            end
            add_word(a, b, rand_prog());
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // no idling between cycles 600 and 1200
    always @(posedge aclk) begin
        cycle <= cycle + 1;
        calm <= (cycle >= 600 && cycle < 1200);
    end

    // driver: hold the word until it is taken, then advance
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_ready) begin
                if (pending_words.size() > 0 && (calm || $urandom_range(0, 99) >= 12)) begin
                    slerp_word_t w;
                    w = pending_words.pop_front();
                    expected_quats.push_back(slerp_predict(w));
                    s_from_x <= w.f[0]; s_from_y <= w.f[1];
                    s_from_z <= w.f[2]; s_from_w <= w.f[3];
                    s_to_x <= w.t[0]; s_to_y <= w.t[1];
                    s_to_z <= w.t[2]; s_to_w <= w.t[3];
                    s_progress <= w.prog;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                    if (pending_words.size() == 0) stimulus_done <= 1'b1;
                end
            end
            m_ready <= calm || $urandom_range(0, 99) >= 12;
        end
    end

    // monitor: compare each result word against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_quats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word at cycle %0d", cycle);
            end else begin
                quat_t e;
                e = expected_quats.pop_front();
                if (e.q[0] !== m_out_x || e.q[1] !== m_out_y ||
                    e.q[2] !== m_out_z || e.q[3] !== m_out_w) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at cycle %0d: expected %0d %0d %0d %0d got %0d %0d %0d %0d",
                                 cycle, e.q[0], e.q[1], e.q[2], e.q[3],
                                 m_out_x, m_out_y, m_out_z, m_out_w);
                end
            end
        end
    end

    // end of run: drain, let the pipeline settle, then report
    initial begin
        fork
            begin
                wait (stimulus_done && expected_quats.size() == 0);
                repeat (LATENCY + 20) @(posedge aclk);
            end
            begin
                wait (cycle >= CYCLE_LIMIT);
                mismatches++;
                $display("timeout with %0d results outstanding", expected_quats.size());
            end
        join_any
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
